### sv/esc_pkg.sv
// Shared types, constants and the control program for the epoch seconds to
// calendar converter. Used by epoch_seconds_to_calendar_core; depends on nothing.
package esc_pkg;

	localparam logic [16:0] ZONE_RESET = 17'd28800;
	localparam logic [11:0] EPOCH_YEAR = 12'd1970;
	localparam logic [3:0]  LAST_MONTH = 4'd11;

	typedef enum logic [3:0] {
		OP_WAIT  = 4'd0,
		OP_DIV   = 4'd1,
		OP_REM   = 4'd2,
		OP_YEAR  = 4'd3,
		OP_MONTH = 4'd4,
		OP_OUT   = 4'd5
	} op_t;

	typedef enum logic [1:0] {
		DV_DAY  = 2'd0,
		DV_HOUR = 2'd1,
		DV_MIN  = 2'd2,
		DV_WEEK = 2'd3
	} div_sel_t;

	// One control word: the operation, the divisor used by a divide or remainder
	// step, and the branch target taken while the operation's loop condition
	// holds. A word marked last falls back to 0.
	typedef struct packed {
		op_t      op;
		div_sel_t dsel;
		logic [3:0] tgt;
		logic     last;
	} uword_t;

	function automatic uword_t ucode(input logic [3:0] pc);
		uword_t w;
		w = '{op: OP_WAIT, dsel: DV_DAY, tgt: 4'd0, last: 1'b0};
		case (pc)
			4'd0:  w = '{op: OP_WAIT,  dsel: DV_DAY,  tgt: 4'd0,  last: 1'b0};
			4'd1:  w = '{op: OP_DIV,   dsel: DV_DAY,  tgt: 4'd1,  last: 1'b0};
			4'd2:  w = '{op: OP_REM,   dsel: DV_DAY,  tgt: 4'd2,  last: 1'b0};
			4'd3:  w = '{op: OP_DIV,   dsel: DV_HOUR, tgt: 4'd3,  last: 1'b0};
			4'd4:  w = '{op: OP_REM,   dsel: DV_HOUR, tgt: 4'd4,  last: 1'b0};
			4'd5:  w = '{op: OP_DIV,   dsel: DV_MIN,  tgt: 4'd5,  last: 1'b0};
			4'd6:  w = '{op: OP_REM,   dsel: DV_MIN,  tgt: 4'd6,  last: 1'b0};
			4'd7:  w = '{op: OP_DIV,   dsel: DV_WEEK, tgt: 4'd7,  last: 1'b0};
			4'd8:  w = '{op: OP_REM,   dsel: DV_WEEK, tgt: 4'd8,  last: 1'b0};
			4'd9:  w = '{op: OP_YEAR,  dsel: DV_DAY,  tgt: 4'd9,  last: 1'b0};
			4'd10: w = '{op: OP_MONTH, dsel: DV_DAY,  tgt: 4'd10, last: 1'b0};
			4'd11: w = '{op: OP_OUT,   dsel: DV_DAY,  tgt: 4'd11, last: 1'b1};
			default: w = '{op: OP_WAIT, dsel: DV_DAY, tgt: 4'd0, last: 1'b1};
		endcase
		return w;
	endfunction

	function automatic logic [16:0] div_value(input div_sel_t sel);
		logic [16:0] d;
		case (sel)
			DV_DAY:  d = 17'd86400;
			DV_HOUR: d = 17'd3600;
			DV_MIN:  d = 17'd60;
			DV_WEEK: d = 17'd7;
			default: d = 17'd86400;
		endcase
		return d;
	endfunction

	// Reciprocals rounded up so that one multiply and a fixed shift give the exact
	// quotient over each operand's range: 86400 is taken as a shift by 7 and 675,
	// 3600 as a shift by 4 and 225, 60 as a shift by 2 and 15.
	function automatic logic [25:0] div_recip(input div_sel_t sel);
		logic [25:0] r;
		case (sel)
			DV_DAY:  r = 26'd50903317; // 2^35 / 675
			DV_HOUR: r = 26'd9321;     // 2^21 / 225
			DV_MIN:  r = 26'd1093;     // 2^14 / 15
			DV_WEEK: r = 26'd74899;    // 2^19 / 7
			default: r = 26'd50903317;
		endcase
		return r;
	endfunction

	// Years reachable from a 32-bit count run from 1970 to 2106, where 2100 is
	// the only multiple of four that is not a leap year.
	function automatic logic is_leap(input logic [11:0] year);
		return (year[1:0] == 2'd0) && (year != 12'd2100);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd0:  n = 5'd31;
			4'd1:  n = leap ? 5'd29 : 5'd28;
			4'd2:  n = 5'd31;
			4'd3:  n = 5'd30;
			4'd4:  n = 5'd31;
			4'd5:  n = 5'd30;
			4'd6:  n = 5'd31;
			4'd7:  n = 5'd31;
			4'd8:  n = 5'd30;
			4'd9:  n = 5'd31;
			4'd10: n = 5'd30;
			4'd11: n = 5'd31;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

### sv/epoch_seconds_to_calendar_core.sv
// Converts a Unix timestamp plus a time-zone offset into a civil date and time.
// Depends on esc_pkg for the control program, divisor constants and calendar tables.
// From input accept to out_valid, eight multiply steps split the count, then the year
// and month subtract loops run. One item at a time: a new one is taken only once the
// sequencer is back in its wait step, later while an earlier result waits. Reset
// clears the sequencer and valid, offset 28800.
module epoch_seconds_to_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] unix_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] cal_year,
	output logic [3:0]  cal_month,
	output logic [4:0]  cal_day,
	output logic [4:0]  cal_hour,
	output logic [5:0]  cal_minute,
	output logic [5:0]  cal_second,
	output logic [2:0]  weekday
);

	logic [16:0] zone_q;
	logic [3:0]  pc_q;
	logic [31:0] num_q;
	logic [15:0] quo_q;
	logic [15:0] days_q;
	logic [11:0] year_q;
	logic [3:0]  mon_q;
	logic        leap_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	logic [2:0]  wday_q;
	logic        out_valid_q;
	logic [11:0] o_year_q;
	logic [3:0]  o_month_q;
	logic [4:0]  o_day_q;
	logic [4:0]  o_hour_q;
	logic [5:0]  o_min_q;
	logic [5:0]  o_sec_q;
	logic [2:0]  o_wday_q;

	esc_pkg::uword_t uw;
	logic [31:0] ts;
	logic [16:0] dvs;
	logic [15:0] wk_base;
	logic [31:0] dv_num;
	logic [25:0] mul_a;
	logic [25:0] mul_b;
	logic [51:0] prod;
	logic [15:0] quo_next;
	logic [31:0] rem_next;
	logic [8:0]  ylen;
	logic        ydone;
	logic [4:0]  mlen;
	logic        mdone;
	logic        out_stall;
	logic        take;
	logic [3:0]  pc_inc;

	assign uw = esc_pkg::ucode(pc_q);
	assign ts = unix_seconds + {{15{zone_q[16]}}, zone_q};

	assign dvs     = esc_pkg::div_value(uw.dsel);
	assign wk_base = days_q + 16'd3;
	assign dv_num  = (uw.dsel == esc_pkg::DV_WEEK) ? {16'd0, wk_base} : num_q;

	// A divide step multiplies the pre-shifted operand by a scaled reciprocal; a
	// remainder step reuses the multiplier for quotient times divisor.
	always_comb begin
		if (uw.op == esc_pkg::OP_REM) begin
			mul_a = {10'd0, quo_q};
			mul_b = {9'd0, dvs};
		end else begin
			case (uw.dsel)
				esc_pkg::DV_DAY:  mul_a = {1'b0, dv_num[31:7]};
				esc_pkg::DV_HOUR: mul_a = {13'd0, dv_num[16:4]};
				esc_pkg::DV_MIN:  mul_a = {16'd0, dv_num[11:2]};
				esc_pkg::DV_WEEK: mul_a = {10'd0, dv_num[15:0]};
				default:          mul_a = {1'b0, dv_num[31:7]};
			endcase
			mul_b = esc_pkg::div_recip(uw.dsel);
		end
	end

	assign prod = {26'd0, mul_a} * {26'd0, mul_b};

	always_comb begin
		case (uw.dsel)
			esc_pkg::DV_DAY:  quo_next = prod[50:35];
			esc_pkg::DV_HOUR: quo_next = prod[36:21];
			esc_pkg::DV_MIN:  quo_next = prod[29:14];
			esc_pkg::DV_WEEK: quo_next = prod[34:19];
			default:          quo_next = prod[50:35];
		endcase
	end

	assign rem_next = dv_num - prod[31:0];

	assign ylen    = esc_pkg::is_leap(year_q) ? 9'd366 : 9'd365;
	assign ydone   = days_q < {7'd0, ylen};
	assign mlen    = esc_pkg::month_len(mon_q, leap_q);
	assign mdone   = (mon_q == esc_pkg::LAST_MONTH) || (days_q < {11'd0, mlen});
	assign out_stall = out_valid_q && !out_ready;

	always_comb begin
		case (uw.op)
			esc_pkg::OP_WAIT:  take = !in_valid;
			esc_pkg::OP_YEAR:  take = !ydone;
			esc_pkg::OP_MONTH: take = !mdone;
			esc_pkg::OP_OUT:   take = out_stall;
			default:           take = 1'b0;
		endcase
	end

	assign pc_inc   = uw.last ? 4'd0 : pc_q + 4'd1;
	assign in_ready = uw.op == esc_pkg::OP_WAIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q      <= esc_pkg::ZONE_RESET;
			pc_q        <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				zone_q <= cfg_wdata;
			end
			pc_q <= take ? uw.tgt : pc_inc;
			if (uw.op == esc_pkg::OP_OUT && !out_stall) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			esc_pkg::OP_WAIT: begin
				num_q  <= ts;
				year_q <= esc_pkg::EPOCH_YEAR;
			end
			esc_pkg::OP_DIV: begin
				quo_q <= quo_next;
			end
			esc_pkg::OP_REM: begin
				num_q <= rem_next;
				case (uw.dsel)
					esc_pkg::DV_DAY:  days_q <= quo_q;
					esc_pkg::DV_HOUR: hour_q <= quo_q[4:0];
					esc_pkg::DV_MIN: begin
						min_q <= quo_q[5:0];
						sec_q <= rem_next[5:0];
					end
					esc_pkg::DV_WEEK: wday_q <= rem_next[2:0] + 3'd1;
					default: begin
					end
				endcase
			end
			esc_pkg::OP_YEAR: begin
				if (ydone) begin
					leap_q <= esc_pkg::is_leap(year_q);
					mon_q  <= 4'd0;
				end else begin
					days_q <= days_q - {7'd0, ylen};
					year_q <= year_q + 12'd1;
				end
			end
			esc_pkg::OP_MONTH: begin
				if (!mdone) begin
					days_q <= days_q - {11'd0, mlen};
					mon_q  <= mon_q + 4'd1;
				end
			end
			esc_pkg::OP_OUT: begin
				if (!out_stall) begin
					o_year_q  <= year_q;
					o_month_q <= mon_q + 4'd1;
					o_day_q   <= days_q[4:0] + 5'd1;
					o_hour_q  <= hour_q;
					o_min_q   <= min_q;
					o_sec_q   <= sec_q;
					o_wday_q  <= wday_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign cal_year   = o_year_q;
	assign cal_month  = o_month_q;
	assign cal_day    = o_day_q;
	assign cal_hour   = o_hour_q;
	assign cal_minute = o_min_q;
	assign cal_second = o_sec_q;
	assign weekday    = o_wday_q;

	// Every remainder step leaves less than the divisor in use.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == esc_pkg::OP_REM) |-> (rem_next < {15'd0, dvs}))
		else $error("divider remainder out of range");

	// After the year loop fewer days than one year are left.
	a_days_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == esc_pkg::OP_MONTH) |-> (days_q < 16'd366))
		else $error("day count above one year in month loop");

	// An accepted item keeps the sequencer busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while busy");

	// A delivered result has a valid month and day of week.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (o_month_q >= 4'd1 && o_month_q <= 4'd12
			&& o_wday_q >= 3'd1 && o_wday_q <= 3'd7))
		else $error("result fields out of range");

endmodule

### sim/epoch_seconds_to_calendar_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for epoch_seconds_to_calendar_core: random and edge timestamps
// under several zone offsets, each result checked against a local calendar conversion.
// Depends on esc_pkg and the core RTL; needs no files or arguments.
module epoch_seconds_to_calendar_core_test;

	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          LONG_HOLD   = 600;
	localparam int          PHASE_ITEMS = 140;
	localparam logic [31:0] DAY_SECS    = 32'd86400;
	localparam logic [31:0] HOUR_SECS   = 32'd3600;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  wday;
	} civil_time_t;

	class calendar_scoreboard;
		logic [16:0]  zone = esc_pkg::ZONE_RESET;
		civil_time_t  expected_dates[$];
		int           errors = 0;
		int           checked = 0;
		int unsigned  month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

		function bit leap_year(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function civil_time_t to_calendar(logic [31:0] secs);
			logic [31:0]  local_secs;
			logic [31:0]  day_count;
			logic [31:0]  day_secs;
			logic [31:0]  left;
			int unsigned  yr;
			int unsigned  mo;
			int unsigned  span;
			civil_time_t  r;
			// The offset is sign-extended and the sum wraps at 32 bits.
			local_secs = secs + {{15{zone[16]}}, zone};
			day_count = local_secs / DAY_SECS;
			day_secs = local_secs % DAY_SECS;
			left = day_count;
			yr = 1970;
			span = leap_year(yr) ? 366 : 365;
			while (left >= span) begin
				left -= span;
				yr++;
				span = leap_year(yr) ? 366 : 365;
			end
			mo = 0;
			span = month_days[0];
			while (mo < 11 && left >= span) begin
				left -= span;
				mo++;
				span = month_days[mo] + ((mo == 1 && leap_year(yr)) ? 1 : 0);
			end
			r.year = 12'(yr);
			r.month = 4'(mo + 1);
			r.day = 5'(left + 1);
			r.hour = 5'(day_secs / HOUR_SECS);
			r.minute = 6'((day_secs % HOUR_SECS) / 60);
			r.second = 6'(day_secs % 60);
			// 1970-01-01 was a Thursday.
			r.wday = 3'((day_count + 3) % 7 + 1);
			return r;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void note_timestamp(logic [31:0] secs);
			expected_dates.push_back(to_calendar(secs));
		endfunction

		task check_date(civil_time_t got);
			civil_time_t want;
			checked++;
			if (expected_dates.size() == 0) begin
				report($sformatf("result %0d arrived with no item pending", checked));
			end else begin
				want = expected_dates.pop_front();
				if (got.year !== want.year)
					report($sformatf("result %0d year %0d, expected %0d", checked, got.year, want.year));
				if (got.month !== want.month)
					report($sformatf("result %0d month %0d, expected %0d", checked, got.month,
						want.month));
				if (got.day !== want.day)
					report($sformatf("result %0d day %0d, expected %0d", checked, got.day, want.day));
				if (got.hour !== want.hour)
					report($sformatf("result %0d hour %0d, expected %0d", checked, got.hour, want.hour));
				if (got.minute !== want.minute)
					report($sformatf("result %0d minute %0d, expected %0d", checked, got.minute,
						want.minute));
				if (got.second !== want.second)
					report($sformatf("result %0d second %0d, expected %0d", checked, got.second,
						want.second));
				if (got.wday !== want.wday)
					report($sformatf("result %0d weekday %0d, expected %0d", checked, got.wday,
						want.wday));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [16:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] unix_seconds;
	logic        out_valid;
	logic        out_ready;
	logic [11:0] cal_year;
	logic [3:0]  cal_month;
	logic [4:0]  cal_day;
	logic [4:0]  cal_hour;
	logic [5:0]  cal_minute;
	logic [5:0]  cal_second;
	logic [2:0]  weekday;

	calendar_scoreboard sb;
	bit                 steady = 1'b0;
	int                 cycles = 0;

	epoch_seconds_to_calendar_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.unix_seconds (unix_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cal_year     (cal_year),
		.cal_month    (cal_month),
		.cal_day      (cal_day),
		.cal_hour     (cal_hour),
		.cal_minute   (cal_minute),
		.cal_second   (cal_second),
		.weekday      (weekday)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_timestamp(unix_seconds);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_date({cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second, weekday});
	end

	// Result side: random stall bursts, plus one long hold-off that backs the core up.
	initial begin
		int stall;
		bit held;
		stall = 0;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else if (!held && sb.checked >= 40) begin
				held = 1'b1;
				stall = LONG_HOLD - 1;
				out_ready = 1'b0;
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(0, 15);
				out_ready = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is taken,
	// with valid still high so the next item can follow without a gap.
	task automatic send_item(input logic [31:0] secs);
		if (!steady && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		unix_seconds = secs;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (sb.expected_dates.size() != 0) @(negedge clk);
		// Leave a few idle cycles before the offset changes.
		repeat (4) @(negedge clk);
	endtask

	task automatic write_zone(input logic [16:0] value);
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.zone = value;
	endtask

	// Half uniform, with a share placed on local midnights so that day, month and
	// year boundaries come up often, and some near either end of the 32-bit range.
	function automatic logic [31:0] random_timestamp(input logic [16:0] zone);
		logic [31:0] sext;
		logic [31:0] r;
		sext = {{15{zone[16]}}, zone};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: r = $urandom;
			5, 6, 7: r = $urandom_range(0, 49710) * DAY_SECS - sext + $urandom_range(0, 4) - 2;
			8: r = $urandom_range(0, 100000000);
			default: r = 32'hFFFF_FFFF - $urandom_range(0, 100000000);
		endcase
		return r;
	endfunction

	initial begin
		logic [31:0] directed [18] = '{
			32'd0, 32'd1, 32'd86399, 32'd86400,
			32'hFFFF_FFFF, 32'hFFFF_8F80, 32'hFFFF_8F7F,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
			32'd951782400,                // 2000-02-29, a century leap day
			32'd978220800, 32'd978307199, // last day of 2000
			32'd4102444799, 32'd4102444800,
			32'd4107542399, 32'd4107542400 // 2100 has no Feb 29
		};
		logic [16:0] zones [7];
		logic [16:0] zone;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		unix_seconds = '0;
		sb = new;
		zones[0] = -17'sd43200;
		zones[1] = 17'sd50400;
		zones[2] = 17'd0;
		zones[3] = 17'h10000;   // most negative offset the register holds
		zones[4] = 17'h0FFFF;   // most positive
		zones[5] = 17'($urandom_range(0, 17'h1FFFF));
		zones[6] = esc_pkg::ZONE_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset offset first.
		foreach (directed[i])
			send_item(directed[i]);
		repeat (PHASE_ITEMS)
			send_item(random_timestamp(sb.zone));

		foreach (zones[p]) begin
			zone = zones[p];
			wait_idle();
			write_zone(zone);
			if (p == 6)
				steady = 1'b1;
			send_item(32'd0);
			send_item(32'hFFFF_FFFF);
			send_item(-{{15{zone[16]}}, zone});
			repeat (PHASE_ITEMS)
				send_item(random_timestamp(zone));
		end

		wait_idle();
		repeat (8) @(negedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
